// ===== rtl/cdq_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cdq_pkg
// Shared types and codes for the circular deque: request codes, result
// status codes, controller states and the controller-to-datapath command.
// ---------------------------------------------------------------------------
package cdq_pkg;

  localparam int ValueW = 32;
  localparam int CapW   = 5;
  localparam int ReqW   = 2;
  localparam int StatW  = 2;

  localparam logic [ReqW-1:0] REQ_PUSH_REAR  = 2'd0;
  localparam logic [ReqW-1:0] REQ_PUSH_FRONT = 2'd1;
  localparam logic [ReqW-1:0] REQ_POP_REAR   = 2'd2;
  localparam logic [ReqW-1:0] REQ_POP_FRONT  = 2'd3;

  localparam logic [StatW-1:0] ST_DONE       = 2'd0;
  localparam logic [StatW-1:0] ST_FULL       = 2'd1;
  localparam logic [StatW-1:0] ST_EMPTY      = 2'd2;

  localparam logic [CapW-1:0] CAP_RESET      = 5'd16;

  typedef enum logic {
    S_IDLE,
    S_OUT
  } cdq_state_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic accept;   // an item is taken at this edge
  } cdq_cmd_t;

endpackage : cdq_pkg
`default_nettype wire

// ===== rtl/circular_deque.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// circular_deque
// Double-ended queue held in a circular slot store of configurable capacity.
// ---------------------------------------------------------------------------
// Each item is a request to push at the rear or front, or pop from the rear
// or front, and gives exactly one result in the cycle after it is accepted. The
// slot store has a registered read port, so the result waits in that register
// and the result flags; a new item is taken in the same cycle the held result
// is taken, so with no output stall the block sustains one item per cycle.
// Writing cfg_wr_data sets the capacity in use (zero acts as one, values
// above DEPTH act as DEPTH) and empties the deque; write it only when idle.
// ---------------------------------------------------------------------------
module circular_deque
  import cdq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [ReqW-1:0]          in_req_type,
  input  wire logic signed [ValueW-1:0] in_push_value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [ValueW-1:0]      out_popped_value,
  output logic [StatW-1:0]              out_status,
  output logic                          out_now_empty,
  output logic                          out_now_full,
  input  wire logic                     cfg_wr_en,
  input  wire logic [CapW-1:0]          cfg_wr_data
);

  cdq_cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  cdq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .req_type     (in_req_type),
    .push_value   (in_push_value),
    .popped_value (out_popped_value),
    .status       (out_status),
    .now_empty    (out_now_empty),
    .now_full     (out_now_full)
  );

endmodule : circular_deque
`default_nettype wire

// ===== rtl/cdq_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cdq_ctrl
// Handshake controller: tracks whether a result is held for the output
// channel and decides when an input item may be taken.
// ---------------------------------------------------------------------------
module cdq_ctrl
  import cdq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  output cdq_cmd_t      cmd
);

  cdq_state_t state_r;
  cdq_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall && !in_valid) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs. A new item may enter in the same cycle the held result leaves.
  always_comb begin
    in_stall   = 1'b0;
    out_valid  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall  = 1'b0;
        out_valid = 1'b0;
      end
      S_OUT: begin
        in_stall  = out_stall;
        out_valid = 1'b1;
      end
      default: begin
        in_stall  = 1'b1;
        out_valid = 1'b0;
      end
    endcase
    cmd.accept = in_valid && !in_stall;
  end

endmodule : cdq_ctrl
`default_nettype wire

// ===== rtl/cdq_dpath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cdq_dpath
// Deque datapath: capacity register, head and tail indices, empty flag,
// slot store with a registered read port, and the result registers.
// ---------------------------------------------------------------------------
module cdq_dpath
  import cdq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cdq_cmd_t          cmd,
  input  wire logic              cfg_wr_en,
  input  wire logic [CapW-1:0]   cfg_wr_data,
  input  wire logic [ReqW-1:0]   req_type,
  input  wire logic [ValueW-1:0] push_value,
  output logic [ValueW-1:0]      popped_value,
  output logic [StatW-1:0]       status,
  output logic                   now_empty,
  output logic                   now_full
);

  localparam int IW    = $clog2(DEPTH);
  localparam int XW    = ((IW > CapW) ? IW : CapW) + 1;
  localparam int DCLIP = (DEPTH > 31) ? 31 : DEPTH;
  localparam logic [CapW-1:0] CAP_MAX = CapW'(DCLIP);

  logic [CapW-1:0]   cap_r, cap_nxt;
  logic [IW-1:0]     head_r, head_nxt;
  logic [IW-1:0]     tail_r, tail_nxt;
  logic              empty_r, empty_nxt;
  logic [StatW-1:0]  status_r, status_nxt;
  logic              pop_ok_r, pop_ok_nxt;
  logic              res_empty_r;
  logic              res_full_r, res_full_nxt;
  logic [ValueW-1:0] rd_data_r;
  logic [ValueW-1:0] mem [DEPTH];

  logic [CapW-1:0]   cap_eff;
  logic [XW-1:0]     cap_x;
  logic [XW-1:0]     hx, tx;
  logic              full_now;
  logic              wr_en, rd_en;
  logic [IW-1:0]     wr_addr, rd_addr;

  function automatic logic [XW-1:0] step_up(input logic [XW-1:0] i,
                                            input logic [XW-1:0] cap);
    logic [XW-1:0] inc;
    inc = i + XW'(1);
    return (inc >= cap) ? '0 : inc;
  endfunction

  function automatic logic [XW-1:0] step_down(input logic [XW-1:0] i,
                                              input logic [XW-1:0] cap);
    return (i == '0 || i >= cap) ? cap - XW'(1) : i - XW'(1);
  endfunction

  // A capacity of zero behaves as one, and anything above the built depth
  // behaves as the depth.
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CapW'(1);
    end else if (cap_r > CAP_MAX) begin
      cap_eff = CAP_MAX;
    end else begin
      cap_eff = cap_r;
    end
    cap_x    = XW'(cap_eff);
    hx       = XW'(head_r);
    tx       = XW'(tail_r);
    full_now = !empty_r && (step_up(tx, cap_x) == hx);
  end

  always_comb begin
    cap_nxt    = cap_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    empty_nxt  = empty_r;
    status_nxt = ST_DONE;
    pop_ok_nxt = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    wr_addr    = '0;
    rd_addr    = (req_type == REQ_POP_REAR) ? tail_r : head_r;

    if (cfg_wr_en) begin
      // Writing the capacity empties the deque; slot contents stay.
      cap_nxt   = cfg_wr_data;
      head_nxt  = '0;
      tail_nxt  = '0;
      empty_nxt = 1'b1;
    end else if (cmd.accept) begin
      case (req_type)
        REQ_PUSH_REAR, REQ_PUSH_FRONT: begin
          if (full_now) begin
            status_nxt = ST_FULL;
          end else if (empty_r) begin
            head_nxt  = '0;
            tail_nxt  = '0;
            empty_nxt = 1'b0;
            wr_en     = 1'b1;
            wr_addr   = '0;
          end else if (req_type == REQ_PUSH_REAR) begin
            tail_nxt = IW'(step_up(tx, cap_x));
            wr_en    = 1'b1;
            wr_addr  = tail_nxt;
          end else begin
            head_nxt = IW'(step_down(hx, cap_x));
            wr_en    = 1'b1;
            wr_addr  = head_nxt;
          end
        end
        REQ_POP_REAR, REQ_POP_FRONT: begin
          if (empty_r) begin
            status_nxt = ST_EMPTY;
          end else begin
            rd_en      = 1'b1;
            pop_ok_nxt = 1'b1;
            if (head_r == tail_r) begin
              head_nxt  = '0;
              tail_nxt  = '0;
              empty_nxt = 1'b1;
            end else if (req_type == REQ_POP_REAR) begin
              tail_nxt = IW'(step_down(tx, cap_x));
            end else begin
              head_nxt = IW'(step_up(hx, cap_x));
            end
          end
        end
        default: status_nxt = ST_DONE;
      endcase
    end

    res_full_nxt = !empty_nxt &&
                   (step_up(XW'(tail_nxt), cap_x) == XW'(head_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CAP_RESET;
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
    end else begin
      cap_r   <= cap_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      status_r    <= status_nxt;
      pop_ok_r    <= pop_ok_nxt;
      res_empty_r <= empty_nxt;
      res_full_r  <= res_full_nxt;
    end
  end

  // Slot store with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= push_value;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign popped_value = pop_ok_r ? rd_data_r : '0;
  assign status       = status_r;
  assign now_empty    = res_empty_r;
  assign now_full     = res_full_r;

endmodule : cdq_dpath
`default_nettype wire

// ===== rtl/cdq_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cdq_checker
// Port-level checks for the circular deque, bound to the top level.
// ---------------------------------------------------------------------------
module cdq_checker
  import cdq_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic [ReqW-1:0]   in_req_type,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [ValueW-1:0] out_popped_value,
  input wire logic [StatW-1:0]  out_status,
  input wire logic              out_now_empty,
  input wire logic              out_now_full
);

  // A held result must not change while stalled.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_popped_value) &&
      $stable(out_status) && $stable(out_now_empty) && $stable(out_now_full))
    else $error("stalled result changed");

  // Every accepted item shows its result in the next cycle.
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item gave no result");

  // A push that was taken leaves the deque non-empty.
  a_push: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall &&
      (in_req_type == REQ_PUSH_REAR || in_req_type == REQ_PUSH_FRONT)
      |=> !out_now_empty)
    else $error("push left the deque empty");

  // Refusals agree with the reported fill state and return zero.
  a_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL || out_status == ST_EMPTY)
      |-> out_popped_value == '0 &&
          (out_status != ST_FULL || out_now_full) &&
          (out_status != ST_EMPTY || out_now_empty))
    else $error("refusal inconsistent with flags");

endmodule : cdq_checker

bind circular_deque cdq_checker u_cdq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_req_type      (in_req_type),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_popped_value (out_popped_value),
  .out_status       (out_status),
  .out_now_empty    (out_now_empty),
  .out_now_full     (out_now_full)
);
`default_nettype wire
